// ----- design/gvf_pkg.sv -----
// ----------------------------------------------------------------------------
// gvf_pkg
// Shared widths, register indexes and configuration type for the GARCH
// conditional variance filter.
// ----------------------------------------------------------------------------
package gvf_pkg;

    localparam int VAL_W          = 40;
    localparam int COEF_W         = 32;
    localparam int FRAC_SHIFT     = 30;
    localparam int PROD_W         = COEF_W + VAL_W + 1;
    localparam int SUM_W          = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int ORDER_W        = 2;
    localparam int MAX_ARCH_LAGS  = 2;
    localparam int MAX_GARCH_LAGS = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OMEGA            = 3'd0,
        REG_ARCH_COEF_1      = 3'd1,
        REG_ARCH_COEF_2      = 3'd2,
        REG_GARCH_COEF_1     = 3'd3,
        REG_GARCH_COEF_2     = 3'd4,
        REG_ARCH_ORDER       = 3'd5,
        REG_GARCH_ORDER      = 3'd6,
        REG_INITIAL_VARIANCE = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] omega;
        logic signed [COEF_W-1:0] arch_coef_1;
        logic signed [COEF_W-1:0] arch_coef_2;
        logic signed [COEF_W-1:0] garch_coef_1;
        logic signed [COEF_W-1:0] garch_coef_2;
        logic [ORDER_W-1:0]       arch_order;
        logic [ORDER_W-1:0]       garch_order;
        logic [VAL_W-1:0]         initial_variance;
    } cfg_t;

endpackage

// ----- design/gvf_sample_if.sv -----
// ----------------------------------------------------------------------------
// gvf_sample_if
// Input channel: one squared residual and a series start mark per beat.
// ----------------------------------------------------------------------------
interface gvf_sample_if;

    logic                      valid;
    logic                      ready;
    logic [gvf_pkg::VAL_W-1:0] residual_sq;
    logic                      series_start;

    modport source (output valid, output residual_sq, output series_start, input ready);
    modport sink   (input valid, input residual_sq, input series_start, output ready);

endinterface

// ----- design/gvf_result_if.sv -----
// ----------------------------------------------------------------------------
// gvf_result_if
// Output channel: one conditional variance and saturation flag per beat.
// ----------------------------------------------------------------------------
interface gvf_result_if;

    logic                      valid;
    logic                      ready;
    logic [gvf_pkg::VAL_W-1:0] variance;
    logic                      saturated;

    modport source (output valid, output variance, output saturated, input ready);
    modport sink   (input valid, input variance, input saturated, output ready);

endinterface

// ----- design/gvf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// gvf_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module gvf_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [gvf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gvf_pkg::VAL_W-1:0]      cfg_wdata,
    output gvf_pkg::cfg_t                  cfg
);

    gvf_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.omega            <= '0;
            cfg_reg.arch_coef_1      <= '0;
            cfg_reg.arch_coef_2      <= '0;
            cfg_reg.garch_coef_1     <= '0;
            cfg_reg.garch_coef_2     <= '0;
            cfg_reg.arch_order       <= gvf_pkg::ORDER_W'(1);
            cfg_reg.garch_order      <= gvf_pkg::ORDER_W'(1);
            cfg_reg.initial_variance <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (gvf_pkg::cfg_reg_t'(cfg_index))
                gvf_pkg::REG_OMEGA:
                    cfg_reg.omega <= cfg_wdata[gvf_pkg::COEF_W-1:0];
                gvf_pkg::REG_ARCH_COEF_1:
                    cfg_reg.arch_coef_1 <= cfg_wdata[gvf_pkg::COEF_W-1:0];
                gvf_pkg::REG_ARCH_COEF_2:
                    cfg_reg.arch_coef_2 <= cfg_wdata[gvf_pkg::COEF_W-1:0];
                gvf_pkg::REG_GARCH_COEF_1:
                    cfg_reg.garch_coef_1 <= cfg_wdata[gvf_pkg::COEF_W-1:0];
                gvf_pkg::REG_GARCH_COEF_2:
                    cfg_reg.garch_coef_2 <= cfg_wdata[gvf_pkg::COEF_W-1:0];
                gvf_pkg::REG_ARCH_ORDER:
                    cfg_reg.arch_order <= cfg_wdata[gvf_pkg::ORDER_W-1:0];
                gvf_pkg::REG_GARCH_ORDER:
                    cfg_reg.garch_order <= cfg_wdata[gvf_pkg::ORDER_W-1:0];
                gvf_pkg::REG_INITIAL_VARIANCE:
                    cfg_reg.initial_variance <= cfg_wdata;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/gvf_variance_calc.sv -----
// ----------------------------------------------------------------------------
// gvf_variance_calc
// Weighted sum of omega and the lagged residuals and variances, truncated
// products, saturated to the unsigned Q8.32 range; a series start passes initial_variance.
// ----------------------------------------------------------------------------
module gvf_variance_calc
(
    input  gvf_pkg::cfg_t              cfg,
    input  logic                       series_start,
    input  logic [gvf_pkg::VAL_W-1:0]  res_hist [gvf_pkg::MAX_ARCH_LAGS],
    input  logic [gvf_pkg::VAL_W-1:0]  var_hist [gvf_pkg::MAX_GARCH_LAGS],
    output logic [gvf_pkg::VAL_W-1:0]  variance,
    output logic                       saturated
);

    localparam int OMEGA_PAD = gvf_pkg::SUM_W - gvf_pkg::COEF_W - 2;

    // floor(c * v / 2^30), exact product then arithmetic shift
    function automatic logic signed [gvf_pkg::SUM_W-1:0] mul_q
    (
        input logic signed [gvf_pkg::COEF_W-1:0] c,
        input logic [gvf_pkg::VAL_W-1:0]         v
    );
        logic signed [gvf_pkg::PROD_W-1:0] prod;
        prod = c * $signed({1'b0, v});
        prod = prod >>> gvf_pkg::FRAC_SHIFT;
        return prod[gvf_pkg::SUM_W-1:0];
    endfunction

    logic signed [gvf_pkg::SUM_W-1:0] omega_term;
    logic signed [gvf_pkg::SUM_W-1:0] arch_term_1;
    logic signed [gvf_pkg::SUM_W-1:0] arch_term_2;
    logic signed [gvf_pkg::SUM_W-1:0] garch_term_1;
    logic signed [gvf_pkg::SUM_W-1:0] garch_term_2;
    logic signed [gvf_pkg::SUM_W-1:0] sum;

    // orders of three count as two
    assign omega_term   = {{OMEGA_PAD{cfg.omega[gvf_pkg::COEF_W-1]}}, cfg.omega, 2'b00};
    assign arch_term_1  = (cfg.arch_order != '0) ? mul_q(cfg.arch_coef_1, res_hist[0]) : '0;
    assign arch_term_2  = cfg.arch_order[1] ? mul_q(cfg.arch_coef_2, res_hist[1]) : '0;
    assign garch_term_1 = (cfg.garch_order != '0) ? mul_q(cfg.garch_coef_1, var_hist[0]) : '0;
    assign garch_term_2 = cfg.garch_order[1] ? mul_q(cfg.garch_coef_2, var_hist[1]) : '0;

    assign sum = omega_term + arch_term_1 + arch_term_2 + garch_term_1 + garch_term_2;

    always_comb
    begin
        if (series_start)
        begin
            variance  = cfg.initial_variance;
            saturated = 1'b0;
        end
        else if (sum[gvf_pkg::SUM_W-1])
        begin
            variance  = '0;
            saturated = 1'b1;
        end
        else if (sum[gvf_pkg::SUM_W-2:gvf_pkg::VAL_W] != '0)
        begin
            variance  = '1;
            saturated = 1'b1;
        end
        else
        begin
            variance  = sum[gvf_pkg::VAL_W-1:0];
            saturated = 1'b0;
        end
    end

endmodule

// ----- design/garch_variance_filter_core.sv -----
// ----------------------------------------------------------------------------
// garch_variance_filter_core
// GARCH(p,q) conditional variance filter, up to two lags of each kind.
// ----------------------------------------------------------------------------
// One beat is accepted every clock cycle while result.ready stays high, a
// sustained rate of one item per cycle. Each result appears after an input
// register and a result register. The clock period is set by the loop
// from the variance history through the lag-one variance multiply, the
// five-term sum and the saturation back into the history. A series_start
// beat returns initial_variance and clears both older lags. Configuration
// writes take effect at once and belong to idle periods only.
// ----------------------------------------------------------------------------
module garch_variance_filter_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [gvf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gvf_pkg::VAL_W-1:0]      cfg_wdata,
    gvf_sample_if.sink                     sample,
    gvf_result_if.source                   result
);

    gvf_pkg::cfg_t cfg;

    logic                       s1_valid_reg;
    logic [gvf_pkg::VAL_W-1:0]  s1_res_reg;
    logic                       s1_start_reg;
    logic                       out_valid_reg;
    logic [gvf_pkg::VAL_W-1:0]  out_var_reg;
    logic                       out_sat_reg;
    logic [gvf_pkg::VAL_W-1:0]  res_hist_reg [gvf_pkg::MAX_ARCH_LAGS];
    logic [gvf_pkg::VAL_W-1:0]  var_hist_reg [gvf_pkg::MAX_GARCH_LAGS];
    logic [gvf_pkg::VAL_W-1:0]  var_next;
    logic                       sat_next;
    logic                       advance;
    logic                       take;

    gvf_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gvf_variance_calc u_calc
    (
        .cfg          (cfg),
        .series_start (s1_start_reg),
        .res_hist     (res_hist_reg),
        .var_hist     (var_hist_reg),
        .variance     (var_next),
        .saturated    (sat_next)
    );

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_res_reg   <= sample.residual_sq;
            s1_start_reg <= sample.series_start;
        end
        if (advance)
        begin
            out_var_reg <= var_next;
            out_sat_reg <= sat_next;
        end
    end

    // histories: lag one at index zero, cleared behind a series start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gvf_pkg::MAX_ARCH_LAGS; i++)
                res_hist_reg[i] <= '0;
            for (int i = 0; i < gvf_pkg::MAX_GARCH_LAGS; i++)
                var_hist_reg[i] <= '0;
        end
        else if (advance)
        begin
            res_hist_reg[0] <= s1_res_reg;
            for (int i = 1; i < gvf_pkg::MAX_ARCH_LAGS; i++)
                res_hist_reg[i] <= s1_start_reg ? '0 : res_hist_reg[i-1];
            var_hist_reg[0] <= var_next;
            for (int i = 1; i < gvf_pkg::MAX_GARCH_LAGS; i++)
                var_hist_reg[i] <= s1_start_reg ? '0 : var_hist_reg[i-1];
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.variance  = out_var_reg;
    assign result.saturated = out_sat_reg;

`ifndef SYNTH
    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_start_reg) |=>
            (out_valid_reg && !out_sat_reg && out_var_reg == $past(cfg.initial_variance)))
        else $error("series start beat did not return the initial variance");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_start_reg) |=>
            (res_hist_reg[1] == '0 && var_hist_reg[1] == '0))
        else $error("series start left older history behind");

    a_var_feedback: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (var_hist_reg[0] == out_var_reg))
        else $error("lag-one variance differs from the last result");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result.ready) |-> !sample.ready)
        else $error("input taken while both stages are full and stalled");
`endif

endmodule

// ----- tb/tb_garch_variance_filter_core.sv -----
// ----------------------------------------------------------------------------
// tb_garch_variance_filter_core
// Self-checking bench for the GARCH conditional variance filter. A clocked
// driver feeds residual beats from a backlog queue; a clocked monitor checks
// each result beat against a bit-exact fixed-point predictor of the variance
// recursion. The configuration is changed between phases while the block is
// idle: directed corner cases first, then random series under random gaps,
// a long result stall and a gap-free tail.
// ----------------------------------------------------------------------------
module tb_garch_variance_filter_core;

    import gvf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 150;

    localparam logic signed [79:0] VAR_CEIL = {40'd0, {VAL_W{1'b1}}};
    localparam logic [VAL_W-1:0]   VAL_MAX  = {VAL_W{1'b1}};

    typedef struct {
        logic [VAL_W-1:0] residual_sq;
        logic             series_start;
    } residual_item_t;

    typedef struct {
        logic [VAL_W-1:0] variance;
        logic             saturated;
    } variance_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_wdata;

    gvf_sample_if sample_ch ();
    gvf_result_if result_ch ();

    garch_variance_filter_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_ch.sink),
        .result    (result_ch.source)
    );

    always #2 clk = ~clk;

    // predictor state
    cfg_t             model_cfg;
    logic [VAL_W-1:0] resid_lag [MAX_ARCH_LAGS];
    logic [VAL_W-1:0] var_lag   [MAX_GARCH_LAGS];

    residual_item_t residual_backlog [$];
    variance_beat_t variance_due     [$];

    int  fail_count    = 0;
    int  results_seen  = 0;
    int  hold_req      = 0;
    int  hold_ack      = 0;
    int  stall_cycles  = 0;
    bit  gaps_on       = 1'b0;

    int             src_gap;
    int             sink_gap;
    int             hold_left;
    residual_item_t drive_item;
    variance_beat_t due_beat;

    function automatic logic [VAL_W-1:0] rand_val40();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[VAL_W-1:0];
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sd0;
            3:       return 32'sd1;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_residual();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return rand_val40() >> $urandom_range(4, 24);
            5, 6, 7:       return rand_val40();
            8:             return '0;
            default:       return VAL_MAX;
        endcase
    endfunction

    // floor(c * v / 2^30), exact
    function automatic logic signed [79:0] scaled_product(input logic signed [COEF_W-1:0] c,
                                                           input logic [VAL_W-1:0] v);
        logic signed [79:0] cw;
        logic signed [79:0] vw;
        cw = c;
        vw = {40'd0, v};
        return (cw * vw) >>> FRAC_SHIFT;
    endfunction

    function automatic variance_beat_t next_variance(input logic [VAL_W-1:0] r,
                                                     input logic start);
        variance_beat_t     beat;
        logic signed [79:0] acc;
        int unsigned        p;
        int unsigned        q;
        beat.saturated = 1'b0;
        if (start)
        begin
            foreach (resid_lag[i]) resid_lag[i] = '0;
            foreach (var_lag[i]) var_lag[i] = '0;
            beat.variance = model_cfg.initial_variance;
        end
        else
        begin
            p   = (model_cfg.arch_order > MAX_ARCH_LAGS) ? MAX_ARCH_LAGS : model_cfg.arch_order;
            q   = (model_cfg.garch_order > MAX_GARCH_LAGS) ? MAX_GARCH_LAGS
                                                          : model_cfg.garch_order;
            acc = $signed(model_cfg.omega);
            acc = acc <<< 2;
            if (p >= 1) acc += scaled_product(model_cfg.arch_coef_1, resid_lag[0]);
            if (p >= 2) acc += scaled_product(model_cfg.arch_coef_2, resid_lag[1]);
            if (q >= 1) acc += scaled_product(model_cfg.garch_coef_1, var_lag[0]);
            if (q >= 2) acc += scaled_product(model_cfg.garch_coef_2, var_lag[1]);
            if (acc < 0)
            begin
                beat.variance  = '0;
                beat.saturated = 1'b1;
            end
            else if (acc > VAR_CEIL)
            begin
                beat.variance  = VAL_MAX;
                beat.saturated = 1'b1;
            end
            else
                beat.variance = acc[VAL_W-1:0];
        end
        resid_lag[1] = resid_lag[0];
        resid_lag[0] = r;
        var_lag[1]   = var_lag[0];
        var_lag[0]   = beat.variance;
        return beat;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [VAL_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_OMEGA:            model_cfg.omega            = data[COEF_W-1:0];
            REG_ARCH_COEF_1:      model_cfg.arch_coef_1      = data[COEF_W-1:0];
            REG_ARCH_COEF_2:      model_cfg.arch_coef_2      = data[COEF_W-1:0];
            REG_GARCH_COEF_1:     model_cfg.garch_coef_1     = data[COEF_W-1:0];
            REG_GARCH_COEF_2:     model_cfg.garch_coef_2     = data[COEF_W-1:0];
            REG_ARCH_ORDER:       model_cfg.arch_order       = data[ORDER_W-1:0];
            REG_GARCH_ORDER:      model_cfg.garch_order      = data[ORDER_W-1:0];
            REG_INITIAL_VARIANCE: model_cfg.initial_variance = data;
            default: ;
        endcase
    endtask

    // unused upper data bits carry junk; the block must ignore them
    task automatic apply_cfg(input logic [31:0] om, input logic [31:0] a1,
                             input logic [31:0] a2, input logic [31:0] g1,
                             input logic [31:0] g2, input logic [1:0] ao,
                             input logic [1:0] go, input logic [VAL_W-1:0] iv);
        logic [VAL_W-1:0] junk;
        junk = rand_val40();
        write_reg(REG_OMEGA,            {junk[39:32], om});
        write_reg(REG_ARCH_COEF_1,      {junk[31:24], a1});
        write_reg(REG_ARCH_COEF_2,      {junk[23:16], a2});
        write_reg(REG_GARCH_COEF_1,     {junk[15:8], g1});
        write_reg(REG_GARCH_COEF_2,     {junk[7:0], g2});
        write_reg(REG_ARCH_ORDER,       {junk[39:2], ao});
        write_reg(REG_GARCH_ORDER,      {~junk[39:2], go});
        write_reg(REG_INITIAL_VARIANCE, iv);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_item(input logic [VAL_W-1:0] r, input logic start);
        residual_item_t it;
        it.residual_sq   = r;
        it.series_start  = start;
        residual_backlog.push_back(it);
    endtask

    // waits until the backlog is sent and every result is back, then the pipe settles
    task automatic wait_idle();
        while (residual_backlog.size() != 0 || sample_ch.valid || variance_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid        <= 1'b0;
            sample_ch.residual_sq  <= '0;
            sample_ch.series_start <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                variance_due.push_back(next_variance(sample_ch.residual_sq,
                                                     sample_ch.series_start));
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (src_gap == 0 && gaps_on && $urandom_range(0, 11) == 0)
                    src_gap = $urandom_range(1, 16);
                if (src_gap > 0)
                begin
                    src_gap--;
                    sample_ch.valid <= 1'b0;
                end
                else if (residual_backlog.size() != 0)
                begin
                    drive_item = residual_backlog.pop_front();
                    sample_ch.valid        <= 1'b1;
                    sample_ch.residual_sq  <= drive_item.residual_sq;
                    sample_ch.series_start <= drive_item.series_start;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            sink_gap  = 0;
            hold_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (variance_due.size() == 0)
                    note_failure($sformatf("beat %0d: unexpected result variance %h sat %b",
                                           results_seen, result_ch.variance,
                                           result_ch.saturated));
                else
                begin
                    due_beat = variance_due.pop_front();
                    if (result_ch.variance !== due_beat.variance ||
                        result_ch.saturated !== due_beat.saturated)
                        note_failure($sformatf(
                            "beat %0d: expected variance %h sat %b, got variance %h sat %b",
                            results_seen, due_beat.variance, due_beat.saturated,
                            result_ch.variance, result_ch.saturated));
                end
            end
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (sink_gap == 0 && gaps_on && $urandom_range(0, 11) == 0)
                sink_gap = $urandom_range(1, 16);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int               ph;
        int               n;
        int               len;
        logic [31:0]      c [5];
        logic [1:0]       ao;
        logic [1:0]       go;
        logic [VAL_W-1:0] iv;

        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_index              = REG_OMEGA;
        cfg_wdata              = '0;

        model_cfg                  = '0;
        model_cfg.arch_order       = 2'd1;
        model_cfg.garch_order      = 2'd1;
        foreach (resid_lag[i]) resid_lag[i] = '0;
        foreach (var_lag[i]) var_lag[i] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, no series start yet
        queue_item(VAL_MAX, 1'b0);
        queue_item('0, 1'b0);
        queue_item(rand_val40(), 1'b0);
        queue_item(VAL_MAX, 1'b1);
        queue_item(VAL_MAX, 1'b0);
        queue_item(rand_val40(), 1'b0);
        wait_idle();

        // largest weights of both signs, full orders: clamp high
        apply_cfg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 2'd2, 2'd2, VAL_MAX);
        queue_item(VAL_MAX, 1'b1);
        queue_item(VAL_MAX, 1'b0);
        queue_item(VAL_MAX, 1'b0);
        queue_item('0, 1'b0);
        queue_item(VAL_MAX, 1'b0);
        wait_idle();

        // most negative everywhere, order 3 clamps to two: clamp at zero
        apply_cfg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 2'd3, 2'd3, '0);
        queue_item(VAL_MAX, 1'b1);
        queue_item(VAL_MAX, 1'b0);
        queue_item(VAL_MAX, 1'b0);
        queue_item('0, 1'b0);
        wait_idle();

        // both orders zero: omega alone
        apply_cfg(32'h4000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 2'd0, 2'd0, rand_val40());
        queue_item(rand_val40(), 1'b1);
        queue_item(VAL_MAX, 1'b0);
        queue_item(VAL_MAX, 1'b0);
        wait_idle();

        // typical fitted model
        apply_cfg(32'h0001_0000, 32'd107374182, 32'd53687091, 32'd858993459,
                  32'd53687091, 2'd1, 2'd2, 40'h00_4000_0000);
        queue_item(40'h01_0000_0000, 1'b1);
        queue_item(40'h00_8000_0000, 1'b0);
        queue_item(40'h03_0000_0000, 1'b0);
        queue_item(40'h00_0000_1234, 1'b0);
        queue_item(40'h00_2000_0000, 1'b0);
        wait_idle();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            ao = 2'($urandom_range(0, 3));
            go = 2'($urandom_range(0, 3));
            case (ph % 4)
                0:
                begin
                    c[0] = $urandom_range(0, 32'h0100_0000);
                    c[1] = $urandom_range(0, 322122547);
                    c[2] = $urandom_range(0, 214748364);
                    c[3] = $urandom_range(0, 1020054732);
                    c[4] = $urandom_range(0, 107374182);
                    iv   = rand_val40() >> 8;
                end
                1:
                begin
                    foreach (c[i]) c[i] = $urandom();
                    iv = rand_val40();
                end
                2:
                begin
                    foreach (c[i]) c[i] = pick_extreme();
                    iv = ($urandom_range(0, 1) != 0) ? VAL_MAX : '0;
                end
                default:
                begin
                    foreach (c[i]) c[i] = $signed($urandom()) >>> $urandom_range(2, 12);
                    iv = rand_val40() >> $urandom_range(0, 20);
                end
            endcase
            apply_cfg(c[0], c[1], c[2], c[3], c[4], ao, go, iv);

            gaps_on = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);

            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    len = $urandom_range(1, 30);
                    for (int k = 0; k < len; k++)
                        queue_item(pick_residual(), k == 0);
                end
                else
                begin
                    len = $urandom_range(1, 10);
                    for (int k = 0; k < len; k++)
                        queue_item(pick_residual(), 1'($urandom_range(0, 1)));
                end
                n += len;
            end

            // long result stall while the sender keeps offering
            if (ph == 4)
            begin
                repeat (20) @(posedge clk);
                hold_req++;
            end
            wait_idle();
        end

        if (variance_due.size() != 0)
            note_failure($sformatf("%0d expected results never arrived", variance_due.size()));

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
